### src/diff_drive_odometry_top_assert.svh
`ifndef DIFF_DRIVE_ODOMETRY_TOP_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_ASSERT_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddo assertion failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddo assertion failed");

`endif

### src/ddo_pkg.sv
package ddo_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 2'd1;

    localparam logic [23:0] INV_WB_RESET    = 24'd193892;
    localparam logic [15:0] TIME_STEP_RESET = 16'd6554;

    localparam logic [29:0] INV_PI_Q30      = 30'd341782638;
    localparam logic [32:0] CORDIC_GAIN_Q30 = 33'd652032874;
    localparam int          CORDIC_STEPS    = 24;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_D     = 4'd1;
    localparam logic [3:0] OP_M     = 4'd2;
    localparam logic [3:0] OP_PH    = 4'd3;
    localparam logic [3:0] OP_PL    = 4'd4;
    localparam logic [3:0] OP_AH    = 4'd5;
    localparam logic [3:0] OP_AL    = 4'd6;
    localparam logic [3:0] OP_CINIT = 4'd7;
    localparam logic [3:0] OP_CITER = 4'd8;
    localparam logic [3:0] OP_XH    = 4'd9;
    localparam logic [3:0] OP_XL    = 4'd10;
    localparam logic [3:0] OP_YH    = 4'd11;
    localparam logic [3:0] OP_YL    = 4'd12;
    localparam logic [3:0] OP_UPD   = 4'd13;

    typedef struct packed {
        logic       load;
        logic       out_load;
        logic [3:0] op;
        logic [4:0] iter;
    } ddo_cmd_t;

    function automatic logic [32:0] atan_lut(input logic [4:0] i);
        logic [32:0] r;
        begin
            case (i)
                5'd0:  r = 33'h020000000;
                5'd1:  r = 33'h012E4051E;
                5'd2:  r = 33'h009FB385B;
                5'd3:  r = 33'h0051111D4;
                5'd4:  r = 33'h0028B0D43;
                5'd5:  r = 33'h00145D7E1;
                5'd6:  r = 33'h000A2F61E;
                5'd7:  r = 33'h000517C55;
                5'd8:  r = 33'h00028BE53;
                5'd9:  r = 33'h000145F2F;
                5'd10: r = 33'h0000A2F98;
                5'd11: r = 33'h0000517CC;
                5'd12: r = 33'h000028BE6;
                5'd13: r = 33'h0000145F3;
                5'd14: r = 33'h00000A2FA;
                5'd15: r = 33'h00000517D;
                5'd16: r = 33'h0000028BE;
                5'd17: r = 33'h00000145F;
                5'd18: r = 33'h000000A30;
                5'd19: r = 33'h000000518;
                5'd20: r = 33'h00000028C;
                5'd21: r = 33'h000000146;
                5'd22: r = 33'h0000000A3;
                5'd23: r = 33'h000000051;
                default: r = 33'h0;
            endcase
            return r;
        end
    endfunction

endpackage

### src/ddo_datapath.sv
module ddo_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ddo_pkg::ddo_cmd_t               cmd,
    input  logic                            cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [23:0]                     cfg_data,
    input  logic signed [15:0]              vel_left,
    input  logic signed [15:0]              vel_right,
    input  logic                            fix_valid,
    input  logic signed [31:0]              fix_x,
    input  logic signed [31:0]              fix_y,
    input  logic signed [15:0]              fix_heading,
    output logic signed [31:0]              out_x,
    output logic signed [31:0]              out_y,
    output logic signed [15:0]              out_heading
);

    logic [23:0]        inv_wb_reg;
    logic [15:0]        dt_reg;
    logic signed [31:0] pose_x_reg, pose_x_next;
    logic signed [31:0] pose_y_reg, pose_y_next;
    logic signed [15:0] pose_h_reg, pose_h_next;

    logic signed [15:0] vl_reg, vr_reg;
    logic signed [33:0] d_reg;
    logic signed [41:0] m_reg;
    logic signed [67:0] acc_reg, acc_next;
    logic [16:0]        pr_lo_reg;
    logic signed [43:0] a_reg;
    logic signed [31:0] dx_reg;
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic signed [15:0] oh_reg;

    logic signed [16:0] vsum, vdiff;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod;
    logic signed [32:0] cosv, sinv, trig;
    logic signed [43:0] a_now, hsum;
    logic [31:0]        mid, ang_adj;
    logic               wrap;
    logic signed [67:0] rnd;
    logic signed [31:0] dround;
    logic signed [32:0] xs, ys, atan_v;

    assign vsum  = 17'(vl_reg) + 17'(vr_reg);
    assign vdiff = 17'(vr_reg) - 17'(vl_reg);
    assign cosv  = neg_reg ? -cx_reg : cx_reg;
    assign sinv  = neg_reg ? -cy_reg : cy_reg;
    assign trig  = (cmd.op == ddo_pkg::OP_XH || cmd.op == ddo_pkg::OP_XL) ? cosv : sinv;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ddo_pkg::OP_D:
            begin
                mul_a = 34'(vsum);
                mul_b = {2'b00, dt_reg};
            end
            ddo_pkg::OP_M:
            begin
                mul_a = {10'd0, inv_wb_reg};
                mul_b = 18'(vdiff);
            end
            ddo_pkg::OP_PH:
            begin
                mul_a = 34'(signed'(m_reg[41:17]));
                mul_b = {2'b00, dt_reg};
            end
            ddo_pkg::OP_PL:
            begin
                mul_a = {17'd0, m_reg[16:0]};
                mul_b = {2'b00, dt_reg};
            end
            ddo_pkg::OP_AH:
            begin
                mul_a = {4'd0, ddo_pkg::INV_PI_Q30};
                mul_b = 18'(signed'(acc_reg[57:41]));
            end
            ddo_pkg::OP_AL:
            begin
                mul_a = {4'd0, ddo_pkg::INV_PI_Q30};
                mul_b = {1'b0, pr_lo_reg};
            end
            ddo_pkg::OP_XH, ddo_pkg::OP_YH:
            begin
                mul_a = 34'(trig);
                mul_b = 18'(signed'(d_reg[33:17]));
            end
            ddo_pkg::OP_XL, ddo_pkg::OP_YL:
            begin
                mul_a = 34'(trig);
                mul_b = {1'b0, d_reg[16:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 52'(mul_a) * 52'(mul_b);

    always_comb
    begin
        case (cmd.op)
            ddo_pkg::OP_PH, ddo_pkg::OP_AH, ddo_pkg::OP_XH, ddo_pkg::OP_YH:
                acc_next = 68'(prod);
            ddo_pkg::OP_PL, ddo_pkg::OP_AL, ddo_pkg::OP_XL, ddo_pkg::OP_YL:
                acc_next = (acc_reg <<< 17) + 68'(prod);
            default:
                acc_next = acc_reg;
        endcase
    end

    // dtheta in binary-angle units, 16 fraction bits
    assign a_now   = acc_reg[62:19];
    assign mid     = {pose_h_reg, 16'd0} + 32'(a_now >>> 1);
    assign wrap    = ang_adj[31];
    assign ang_adj = mid + 32'h4000_0000;

    assign rnd    = acc_reg + (68'sd1 <<< 42);
    assign dround = 32'(signed'(rnd[67:43]));
    assign hsum   = a_reg + 44'sd32768;

    assign atan_v = signed'(ddo_pkg::atan_lut(cmd.iter));
    assign xs     = cx_reg >>> cmd.iter;
    assign ys     = cy_reg >>> cmd.iter;

    always_comb
    begin
        pose_x_next = pose_x_reg;
        pose_y_next = pose_y_reg;
        pose_h_next = pose_h_reg;
        if (cmd.load && fix_valid)
        begin
            pose_x_next = fix_x;
            pose_y_next = fix_y;
            pose_h_next = fix_heading;
        end
        else if (cmd.op == ddo_pkg::OP_UPD)
        begin
            pose_x_next = pose_x_reg + dx_reg;
            pose_y_next = pose_y_reg + dround;
            pose_h_next = pose_h_reg + signed'(hsum[31:16]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_wb_reg <= ddo_pkg::INV_WB_RESET;
            dt_reg     <= ddo_pkg::TIME_STEP_RESET;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            pose_h_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == ddo_pkg::REG_INV_WHEEL_BASE)
                inv_wb_reg <= cfg_data;
            if (cfg_we && cfg_index == ddo_pkg::REG_TIME_STEP)
                dt_reg <= cfg_data[15:0];
            pose_x_reg <= pose_x_next;
            pose_y_reg <= pose_y_next;
            pose_h_reg <= pose_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vl_reg <= vel_left;
            vr_reg <= vel_right;
        end
        acc_reg <= acc_next;
        if (cmd.op == ddo_pkg::OP_D)
            d_reg <= prod[33:0];
        if (cmd.op == ddo_pkg::OP_M)
            m_reg <= prod[41:0];
        if (cmd.op == ddo_pkg::OP_AH)
            pr_lo_reg <= acc_reg[40:24];
        if (cmd.op == ddo_pkg::OP_CINIT)
        begin
            a_reg   <= a_now;
            neg_reg <= wrap;
            cx_reg  <= signed'(ddo_pkg::CORDIC_GAIN_Q30);
            cy_reg  <= '0;
            cz_reg  <= 33'(signed'(wrap ? mid + 32'h8000_0000 : mid));
        end
        if (cmd.op == ddo_pkg::OP_CITER)
        begin
            if (!cz_reg[32])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_v;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.op == ddo_pkg::OP_YH)
            dx_reg <= dround;
        if (cmd.out_load)
        begin
            ox_reg <= pose_x_reg;
            oy_reg <= pose_y_reg;
            oh_reg <= pose_h_reg;
        end
    end

    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_heading = oh_reg;

endmodule

### src/ddo_ctrl.sv
module ddo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              fix_valid,
    output logic              out_valid,
    input  logic              out_ready,
    output ddo_pkg::ddo_cmd_t cmd
);

    `include "diff_drive_odometry_top_assert.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [5:0] STEP_ITER0 = 6'd7;
    localparam logic [5:0] STEP_LAST  = 6'd35;

    logic [1:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, slot_free;
    logic [3:0] op;
    logic [5:0] iter_full;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign iter_full = step_reg - STEP_ITER0;

    always_comb
    begin
        case (step_reg) inside
            6'd0:     op = ddo_pkg::OP_D;
            6'd1:     op = ddo_pkg::OP_M;
            6'd2:     op = ddo_pkg::OP_PH;
            6'd3:     op = ddo_pkg::OP_PL;
            6'd4:     op = ddo_pkg::OP_AH;
            6'd5:     op = ddo_pkg::OP_AL;
            6'd6:     op = ddo_pkg::OP_CINIT;
            [6'd7:6'd30]: op = ddo_pkg::OP_CITER;
            6'd31:    op = ddo_pkg::OP_XH;
            6'd32:    op = ddo_pkg::OP_XL;
            6'd33:    op = ddo_pkg::OP_YH;
            6'd34:    op = ddo_pkg::OP_YL;
            6'd35:    op = ddo_pkg::OP_UPD;
            default:  op = ddo_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        cmd.load     = accept;
        cmd.out_load = (state_reg == S_DONE) && slot_free;
        cmd.op       = (state_reg == S_RUN) ? op : ddo_pkg::OP_NONE;
        cmd.iter     = iter_full[4:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = fix_valid ? S_DONE : S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == STEP_LAST)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `DDO_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE)
    `DDO_ASSERT_NEXT(a_done_loads, state_reg == S_DONE && slot_free, out_valid_reg)
    `DDO_ASSERT_NOW(a_step_bound, state_reg == S_RUN, step_reg <= STEP_LAST)
    `DDO_ASSERT_NEXT(a_run_advance, state_reg == S_RUN && step_reg != STEP_LAST,
                     state_reg == S_RUN)

endmodule

### src/diff_drive_odometry_top.sv
// Differential-drive odometry: each word on the input channel is one tick. A tick with
// fix_valid set loads the fix into the pose; otherwise the pose is dead-reckoned with a
// midpoint heading and a 24-step CORDIC. One pose word comes out per tick. A fix tick
// goes from idle straight to the done state; a dead-reckoning tick makes ten passes
// through one shared 34x18 multiplier, a CORDIC setup step, the 24 CORDIC iterations and
// the pose update, run one after the other. One tick is in flight at a time; the next is
// accepted while the previous pose word still waits on the output, and a finished tick
// holds until that word is taken. Config writes are always ready and should be made
// while no tick is in flight; index 0 is the inverse wheel base, index 1 the time step.
module diff_drive_odometry_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [23:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              vel_left,
    input  logic signed [15:0]              vel_right,
    input  logic                            fix_valid,
    input  logic signed [31:0]              fix_x,
    input  logic signed [31:0]              fix_y,
    input  logic signed [15:0]              fix_heading,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [31:0]              out_x,
    output logic signed [31:0]              out_y,
    output logic signed [15:0]              out_heading
);

    ddo_pkg::ddo_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fix_valid (fix_valid),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ddo_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .vel_left    (vel_left),
        .vel_right   (vel_right),
        .fix_valid   (fix_valid),
        .fix_x       (fix_x),
        .fix_y       (fix_y),
        .fix_heading (fix_heading),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_heading (out_heading)
    );

endmodule
